[rtl/sfr_pkg.sv]
// Shared types, constants and glyph tables for the stroke font text renderer.
// Used by the shared add unit and the top level.
package sfr_pkg;

  localparam int MAX_GLYPH_POINTS = 11;
  localparam int GLYPH_COUNT      = 14;

  // Configuration register indexes.
  localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd2;
  localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd3;
  localparam logic [2:0] REG_CHAR_SPACING = 3'd4;
  localparam logic [2:0] REG_BEAM_SLEW    = 3'd5;

  localparam logic signed [17:0] PEN_MAX = 18'sd32767;

  typedef enum logic [1:0] {
    S_IDLE,
    S_X,
    S_Y,
    S_ADV
  } sfr_state_t;

  // Operands of the shared add unit: base + mult * scale, mult in 0..2.
  typedef struct packed {
    logic signed [17:0] base;
    logic [14:0]        scale;
    logic [1:0]         mult;
  } alu_op_t;

  typedef struct packed {
    logic [1:0] row;
    logic [1:0] col;
  } grid_pos_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } glyph_sel_t;

  localparam logic [3:0] GLYPH_LEN [GLYPH_COUNT] = '{
    4'd10, 4'd4, 4'd9, 4'd11, 4'd7, 4'd9, 4'd10, 4'd7, 4'd11, 4'd10, 4'd10, 4'd8,
    4'd10, 4'd8
  };

  // Grid cells 0..8, numbered row by row from the top left.
  localparam logic [3:0] GLYPH_ROM [GLYPH_COUNT][MAX_GLYPH_POINTS] = '{
    '{4'd0, 4'd0, 4'd1, 4'd2, 4'd5, 4'd8, 4'd7, 4'd6, 4'd3, 4'd0, 4'd0},
    '{4'd1, 4'd1, 4'd4, 4'd7, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd1, 4'd2, 4'd5, 4'd4, 4'd3, 4'd6, 4'd7, 4'd8, 4'd0, 4'd0},
    '{4'd0, 4'd1, 4'd2, 4'd5, 4'd4, 4'd3, 4'd4, 4'd5, 4'd8, 4'd7, 4'd6},
    '{4'd0, 4'd3, 4'd4, 4'd5, 4'd2, 4'd5, 4'd8, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd2, 4'd1, 4'd0, 4'd3, 4'd4, 4'd5, 4'd8, 4'd7, 4'd6, 4'd0, 4'd0},
    '{4'd2, 4'd1, 4'd0, 4'd3, 4'd6, 4'd7, 4'd8, 4'd5, 4'd4, 4'd3, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd1, 4'd2, 4'd4, 4'd6, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd5, 4'd2, 4'd1, 4'd0, 4'd3, 4'd4, 4'd5, 4'd8, 4'd7, 4'd6, 4'd3},
    '{4'd8, 4'd8, 4'd8, 4'd5, 4'd2, 4'd1, 4'd0, 4'd3, 4'd4, 4'd5, 4'd0},
    '{4'd6, 4'd6, 4'd3, 4'd4, 4'd5, 4'd4, 4'd3, 4'd0, 4'd1, 4'd2, 4'd0},
    '{4'd6, 4'd3, 4'd0, 4'd1, 4'd2, 4'd5, 4'd4, 4'd3, 4'd0, 4'd0, 4'd0},
    '{4'd2, 4'd2, 4'd1, 4'd0, 4'd3, 4'd4, 4'd5, 4'd8, 4'd7, 4'd6, 4'd0},
    '{4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd0, 4'd0, 4'd0}
  };

  function automatic grid_pos_t cell_to_grid(input logic [3:0] cell_num);
    grid_pos_t p;
    case (cell_num)
      4'd0:    p = '{row: 2'd0, col: 2'd0};
      4'd1:    p = '{row: 2'd0, col: 2'd1};
      4'd2:    p = '{row: 2'd0, col: 2'd2};
      4'd3:    p = '{row: 2'd1, col: 2'd0};
      4'd4:    p = '{row: 2'd1, col: 2'd1};
      4'd5:    p = '{row: 2'd1, col: 2'd2};
      4'd6:    p = '{row: 2'd2, col: 2'd0};
      4'd7:    p = '{row: 2'd2, col: 2'd1};
      4'd8:    p = '{row: 2'd2, col: 2'd2};
      default: p = '{row: 2'd0, col: 2'd0};
    endcase
    return p;
  endfunction

  function automatic glyph_sel_t glyph_lookup(input logic [7:0] code);
    glyph_sel_t s;
    s.hit = 1'b1;
    s.idx = 4'd0;
    case (code) inside
      [8'h30:8'h39]: s.idx = code[3:0];
      8'h46:         s.idx = 4'd10;
      8'h50:         s.idx = 4'd11;
      8'h53:         s.idx = 4'd12;
      8'h2E:         s.idx = 4'd13;
      default:       s.hit = 1'b0;
    endcase
    return s;
  endfunction

endpackage

[rtl/sfr_in_if.sv]
// Input channel of the stroke font text renderer: one character per item.
// Depends on nothing but the handshake convention valid/ready.
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       text_start;

  modport source (output valid, output char_code, output text_start, input ready);
  modport sink   (input valid, input char_code, input text_start, output ready);
endinterface

[rtl/sfr_out_if.sv]
// Output channel of the stroke font text renderer: one stroke point per item.
// Depends on nothing but the handshake convention valid/ready.
interface sfr_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] point_x;
  logic signed [17:0] point_y;
  logic               stroke_start;
  logic               last_point;
  logic [15:0]        stroke_slew;

  modport source (output valid, output point_x, output point_y, output stroke_start,
                  output last_point, output stroke_slew, input ready);
  modport sink   (input valid, input point_x, input point_y, input stroke_start,
                  input last_point, input stroke_slew, output ready);
endinterface

[rtl/sfr_alu.sv]
// Shared add unit of the renderer: sum = base + mult * scale with mult 0..2.
// Depends on sfr_pkg for the operand struct.
module sfr_alu (
  input  sfr_pkg::alu_op_t   op,
  output logic signed [17:0] sum
);

  logic signed [17:0] addend;

  always_comb begin
    case (op.mult)
      2'd1:    addend = $signed({3'b000, op.scale});
      2'd2:    addend = $signed({2'b00, op.scale, 1'b0});
      default: addend = 18'sd0;
    endcase
  end

  assign sum = op.base + addend;

endmodule

[rtl/stroke_font_text_renderer_unit.sv]
// Stroke font text renderer: characters in, vector stroke points out.
// Depends on sfr_pkg, sfr_in_if, sfr_out_if and sfr_alu.
//
// The block takes one character per input item and draws digits, F, P, S and
// the period as one polyline on a 3x3 grid, one output item per point, with
// coordinates in half display units. Every point is built by one shared add
// unit in two steps (x, then y); the states per character are the idle state,
// in which the character is taken, the x and y steps for each point and then
// the pen advance; a space or an unsupported character goes from the idle
// state straight to the pen advance. The input is not ready while a
// character is being drawn. A stalled output holds the sequencer in its y
// step. The pen x position is loaded from origin_x when text_start is set and
// then advances by char_spacing after each character (twice for a space),
// saturating at 32767. Configuration writes are taken at any time but must
// only be issued while the block is idle.
module stroke_font_text_renderer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  sfr_in_if.sink      in_ch,
  sfr_out_if.source   out_ch
);

  // Configuration registers.
  logic signed [15:0] origin_x;
  logic signed [15:0] origin_y;
  logic [14:0]        glyph_height;
  logic [14:0]        glyph_width;
  logic [14:0]        char_spacing;
  logic [15:0]        beam_slew;

  // Sequencer state and per-character context.
  sfr_pkg::sfr_state_t state, state_next;
  logic signed [15:0]  pen_x;
  logic [3:0]          glyph_idx;
  logic [3:0]          glyph_len;
  logic [3:0]          pt;
  logic                is_space;
  logic signed [17:0]  x_stage;

  // Output register.
  logic               out_valid;
  logic signed [17:0] out_x;
  logic signed [17:0] out_y;
  logic               out_start;
  logic               out_last;
  logic [15:0]        out_slew;

  sfr_pkg::alu_op_t   alu_op;
  logic signed [17:0] alu_sum;
  sfr_pkg::grid_pos_t grid;
  sfr_pkg::glyph_sel_t in_sel;
  logic               in_take;
  logic               out_room;
  logic               pt_last;
  logic               load_out;
  logic signed [15:0] pen_adv;

  sfr_alu u_alu (
    .op  (alu_op),
    .sum (alu_sum)
  );

  assign in_ch.ready = (state == sfr_pkg::S_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign in_sel      = sfr_pkg::glyph_lookup(in_ch.char_code);
  assign out_room    = !out_valid || out_ch.ready;
  assign grid        = sfr_pkg::cell_to_grid(sfr_pkg::GLYPH_ROM[glyph_idx][pt]);
  assign pt_last     = (pt == glyph_len - 4'd1);

  // The pen only ever moves up, so only the upper bound can be crossed.
  assign pen_adv = (alu_sum > sfr_pkg::PEN_MAX) ? sfr_pkg::PEN_MAX[15:0] : alu_sum[15:0];

  // Next state and operand selection for the shared add unit.
  always_comb begin
    state_next   = state;
    load_out     = 1'b0;
    alu_op.base  = {{2{pen_x[15]}}, pen_x};
    alu_op.scale = char_spacing;
    alu_op.mult  = is_space ? 2'd2 : 2'd1;
    case (state)
      sfr_pkg::S_IDLE: begin
        if (in_take) begin
          state_next = in_sel.hit ? sfr_pkg::S_X : sfr_pkg::S_ADV;
        end
      end
      sfr_pkg::S_X: begin
        // x = 2*pen_x + col*glyph_width
        alu_op.base  = {pen_x[15], pen_x, 1'b0};
        alu_op.scale = glyph_width;
        alu_op.mult  = grid.col;
        state_next   = sfr_pkg::S_Y;
      end
      sfr_pkg::S_Y: begin
        // y = 2*origin_y + (2 - row)*glyph_height
        alu_op.base  = {origin_y[15], origin_y, 1'b0};
        alu_op.scale = glyph_height;
        alu_op.mult  = 2'd2 - grid.row;
        if (out_room) begin
          load_out   = 1'b1;
          state_next = pt_last ? sfr_pkg::S_ADV : sfr_pkg::S_X;
        end
      end
      sfr_pkg::S_ADV: begin
        state_next = sfr_pkg::S_IDLE;
      end
      default: state_next = sfr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= 16'sd0;
      origin_y     <= 16'sd0;
      glyph_height <= 15'd16;
      glyph_width  <= 15'd8;
      char_spacing <= 15'd12;
      beam_slew    <= 16'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        sfr_pkg::REG_ORIGIN_X:     origin_x     <= cfg_data;
        sfr_pkg::REG_ORIGIN_Y:     origin_y     <= cfg_data;
        sfr_pkg::REG_GLYPH_HEIGHT: glyph_height <= cfg_data[14:0];
        sfr_pkg::REG_GLYPH_WIDTH:  glyph_width  <= cfg_data[14:0];
        sfr_pkg::REG_CHAR_SPACING: char_spacing <= cfg_data[14:0];
        sfr_pkg::REG_BEAM_SLEW:    beam_slew    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pen position: loaded at the start of a text, advanced after each character.
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x <= 16'sd0;
    end else if (in_take && in_ch.text_start) begin
      pen_x <= origin_x;
    end else if (state == sfr_pkg::S_ADV) begin
      pen_x <= pen_adv;
    end
  end

  // Point counter and character context.
  always_ff @(posedge clk) begin
    if (rst) begin
      pt <= 4'd0;
    end else if (in_take) begin
      pt <= 4'd0;
    end else if (load_out) begin
      pt <= pt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      glyph_idx <= in_sel.idx;
      glyph_len <= sfr_pkg::GLYPH_LEN[in_sel.idx];
      is_space  <= (in_ch.char_code == 8'h20);
    end
    if (state == sfr_pkg::S_X) begin
      x_stage <= alu_sum;
    end
  end

  // Output register: a loaded point waits here until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_x     <= x_stage;
      out_y     <= alu_sum;
      out_start <= (pt == 4'd0);
      out_last  <= pt_last;
      out_slew  <= beam_slew;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.point_x      = out_x;
  assign out_ch.point_y      = out_y;
  assign out_ch.stroke_start = out_start;
  assign out_ch.last_point   = out_last;
  assign out_ch.stroke_slew  = out_slew;

  // An accepted character always takes the sequencer out of the idle state.
  assert property (@(posedge clk) disable iff (rst)
    in_take |=> state != sfr_pkg::S_IDLE)
    else $error("sequencer stayed idle after taking a character");

  // The point counter never runs past the glyph length while drawing.
  assert property (@(posedge clk) disable iff (rst)
    (state == sfr_pkg::S_X) |-> (pt < glyph_len))
    else $error("point counter beyond glyph length");

  // The pen does not move while points of a glyph are being produced.
  assert property (@(posedge clk) disable iff (rst)
    (state == sfr_pkg::S_X || state == sfr_pkg::S_Y) |=> $stable(pen_x))
    else $error("pen moved in the middle of a glyph");

endmodule
